>>> hdl/tfn_pkg.sv
// Shared types and fixed widths for the triangle face normal unit.
// No dependencies; imported by every module of the unit.
package tfn_pkg;

  localparam int NORM_BITS  = 24;  // width of normalised cross product magnitudes
  localparam int SQ_BITS    = 48;
  localparam int SUM_BITS   = 50;
  localparam int SUM_SHIFT  = 12;
  localparam int X_BITS     = SUM_BITS + SUM_SHIFT;
  localparam int ROOT_BITS  = 31;
  localparam int SQRT_STEPS = 31;
  localparam int FRAC_SHIFT = 21;
  localparam int NUM_BITS   = 46;
  localparam int DEN_BITS   = ROOT_BITS + 1;
  localparam int QUO_BITS   = 16;
  localparam int OUT_BITS   = 16;
  localparam logic [QUO_BITS-1:0] ONE_Q14 = QUO_BITS'(16384);

  typedef logic [2:0][NORM_BITS-1:0] mag_vec_t;
  typedef logic [2:0][QUO_BITS-1:0]  quo_vec_t;

  // Control that travels beside the payload from the sign and magnitude stage onward
  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [2:0] neg;
  } tfn_ctl_t;

endpackage

>>> hdl/triangle_face_normal_unit.sv
// Triangle face normal unit: unit normal of e12 x e01 in signed Q1.14 per triangle.
// Stages: edges, products, cross product, sign, normalise, squares, sum, square root, divider, output.
// Throughput: one triangle per cycle unless m_tready stalls; sqrt and divider stages fully pipelined.
// The whole pipeline holds while a result waits on m_tready.
// Synchronous active-high rst clears all valid bits; payload registers are not reset.
// Depends on tfn_pkg, tfn_sqrt and tfn_div.
module triangle_face_normal_unit import tfn_pkg::*; #(
  parameter int COORD_BITS = 16,
  localparam int IN_W = ((9 * COORD_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z (COORD_BITS each), zero pad
  input  logic [IN_W-1:0] s_tdata,
  output logic            m_tvalid,
  input  logic            m_tready,
  // normal_x, normal_y, normal_z (16 bits each)
  output logic [47:0]     m_tdata,
  // degenerate
  output logic            m_tuser
);

  localparam int EW = COORD_BITS + 1;
  localparam int PW = 2 * EW;
  localparam int CW = PW + 1;
  localparam int MW = 2 * COORD_BITS + 1;
  localparam int LW = MW + NORM_BITS;
  localparam int K  = $clog2(MW);

  logic ce;
  assign ce       = ~m_tvalid | m_tready;
  assign s_tready = ce;

  // stage 1: edges
  logic signed [COORD_BITS-1:0] crd [0:8];
  logic signed [EW-1:0] ea [0:2];
  logic signed [EW-1:0] eb [0:2];
  logic v1, v2, v3;

  for (genvar i = 0; i < 9; i++) begin : g_crd
    assign crd[i] = $signed(s_tdata[i*COORD_BITS +: COORD_BITS]);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        ea[i] <= EW'(crd[6+i]) - EW'(crd[3+i]);
        eb[i] <= EW'(crd[3+i]) - EW'(crd[i]);
      end
    end
  end

  // stage 2: products
  logic signed [PW-1:0] pp [0:2];
  logic signed [PW-1:0] qp [0:2];

  always_ff @(posedge clk) begin
    if (ce) begin
      pp[0] <= PW'(ea[1]) * PW'(eb[2]);
      qp[0] <= PW'(ea[2]) * PW'(eb[1]);
      pp[1] <= PW'(ea[2]) * PW'(eb[0]);
      qp[1] <= PW'(ea[0]) * PW'(eb[2]);
      pp[2] <= PW'(ea[0]) * PW'(eb[1]);
      qp[2] <= PW'(ea[1]) * PW'(eb[0]);
    end
  end

  // stage 3: cross product
  logic signed [CW-1:0] cr [0:2];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        cr[i] <= CW'(pp[i]) - CW'(qp[i]);
      end
    end
  end

  // stage 4: sign and magnitude
  logic [CW-1:0] cabs [0:2];
  logic [MW-1:0] mag [0:2];
  tfn_ctl_t      c4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cabs[i] = cr[i][CW-1] ? CW'(-cr[i]) : CW'(cr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      c4 <= '0;
    end else if (ce) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      c4.valid <= v3;
      c4.degen <= (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
      for (int i = 0; i < 3; i++) begin
        c4.neg[i] <= cr[i][CW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        mag[i] <= cabs[i][MW-1:0];
      end
    end
  end

  // normalise: shift all three so the largest has its top bit at LW-1
  logic [LW-1:0] nm [0:K][0:2];
  logic [LW-1:0] nacc [0:K];
  tfn_ctl_t      nc [0:K];

  for (genvar i = 0; i < 3; i++) begin : g_nm0
    assign nm[0][i] = {mag[i], NORM_BITS'(0)};
  end
  assign nacc[0] = {mag[0] | mag[1] | mag[2], NORM_BITS'(0)};
  assign nc[0]   = c4;

  for (genvar k = 0; k < K; k++) begin : g_norm
    localparam int SH = 1 << (K - 1 - k);
    logic zero_top;
    assign zero_top = (nacc[k][LW-1 -: SH] == '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        nc[k+1] <= '0;
      end else if (ce) begin
        nc[k+1] <= nc[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        nacc[k+1] <= zero_top ? (nacc[k] << SH) : nacc[k];
        for (int i = 0; i < 3; i++) begin
          nm[k+1][i] <= zero_top ? (nm[k][i] << SH) : nm[k][i];
        end
      end
    end
  end

  // squares, then their sum
  mag_vec_t           msq, msum;
  logic [SQ_BITS-1:0] sq [0:2];
  logic [SUM_BITS-1:0] ssum;
  tfn_ctl_t           csq, csum;

  always_ff @(posedge clk) begin
    if (rst) begin
      csq  <= '0;
      csum <= '0;
    end else if (ce) begin
      csq  <= nc[K];
      csum <= csq;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        msq[i] <= nm[K][i][LW-1 -: NORM_BITS];
        sq[i]  <= SQ_BITS'(nm[K][i][LW-1 -: NORM_BITS]) *
                  SQ_BITS'(nm[K][i][LW-1 -: NORM_BITS]);
      end
      msum <= msq;
      ssum <= SUM_BITS'(sq[0]) + SUM_BITS'(sq[1]) + SUM_BITS'(sq[2]);
    end
  end

  tfn_ctl_t             crt;
  mag_vec_t             mrt;
  logic [ROOT_BITS-1:0] root;

  tfn_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_ctl   (csum),
    .in_m     (msum),
    .in_x     ({ssum, SUM_SHIFT'(0)}),
    .out_ctl  (crt),
    .out_m    (mrt),
    .out_root (root)
  );

  tfn_ctl_t cdv;
  quo_vec_t quo;

  tfn_div u_div (
    .clk     (clk),
    .rst     (rst),
    .ce      (ce),
    .in_ctl  (crt),
    .in_m    (mrt),
    .in_root (root),
    .out_ctl (cdv),
    .out_q   (quo)
  );

  // output register: saturate, apply sign, zero a degenerate triangle
  logic [QUO_BITS-1:0] qsat [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qsat[i] = (quo[i] > ONE_Q14) ? ONE_Q14 : quo[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= cdv.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tuser <= cdv.degen;
      for (int i = 0; i < 3; i++) begin
        if (cdv.degen) begin
          m_tdata[i*OUT_BITS +: OUT_BITS] <= '0;
        end else if (cdv.neg[i]) begin
          m_tdata[i*OUT_BITS +: OUT_BITS] <= OUT_BITS'(-qsat[i]);
        end else begin
          m_tdata[i*OUT_BITS +: OUT_BITS] <= OUT_BITS'(qsat[i]);
        end
      end
    end
  end

  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("degenerate result carries a nonzero normal");

  a_normal_nonzero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata != '0)
    else $error("non-degenerate triangle gave a zero normal");

  a_x_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[15:0]) <= 16384 && $signed(m_tdata[15:0]) >= -16384))
    else $error("normal x outside +/-1.0");

  a_z_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[47:32]) <= 16384 && $signed(m_tdata[47:32]) >= -16384))
    else $error("normal z outside +/-1.0");

endmodule

>>> hdl/tfn_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on tfn_pkg; carries the control and magnitudes alongside.
module tfn_sqrt import tfn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ce,
  input  tfn_ctl_t             in_ctl,
  input  mag_vec_t             in_m,
  input  logic [X_BITS-1:0]    in_x,
  output tfn_ctl_t             out_ctl,
  output mag_vec_t             out_m,
  output logic [ROOT_BITS-1:0] out_root
);

  localparam int RW = X_BITS + 1;

  tfn_ctl_t        cl [0:SQRT_STEPS];
  mag_vec_t        mm [0:SQRT_STEPS];
  logic [RW-1:0]   xr [0:SQRT_STEPS];
  logic [RW-1:0]   rs [0:SQRT_STEPS];

  assign cl[0] = in_ctl;
  assign mm[0] = in_m;
  assign xr[0] = RW'(in_x);
  assign rs[0] = '0;

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQRT_STEPS - 1 - s));
    logic [RW-1:0] trial;
    assign trial = rs[s] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        cl[s+1] <= '0;
      end else if (ce) begin
        cl[s+1] <= cl[s];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        mm[s+1] <= mm[s];
        if (xr[s] >= trial) begin
          xr[s+1] <= xr[s] - trial;
          rs[s+1] <= (rs[s] >> 1) + BIT;
        end else begin
          xr[s+1] <= xr[s];
          rs[s+1] <= rs[s] >> 1;
        end
      end
    end
  end

  assign out_ctl  = cl[SQRT_STEPS];
  assign out_m    = mm[SQRT_STEPS];
  assign out_root = rs[SQRT_STEPS][ROOT_BITS-1:0];

endmodule

>>> hdl/tfn_div.sv
// Pipelined restoring divider for the three normal components, one quotient bit per stage.
// Depends on tfn_pkg; quotient is the rounded m * 2^20 / root.
module tfn_div import tfn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ce,
  input  tfn_ctl_t             in_ctl,
  input  mag_vec_t             in_m,
  input  logic [ROOT_BITS-1:0] in_root,
  output tfn_ctl_t             out_ctl,
  output quo_vec_t             out_q
);

  localparam int CMP_BITS = DEN_BITS + QUO_BITS;

  tfn_ctl_t            cl [0:QUO_BITS];
  logic [DEN_BITS-1:0] dd [0:QUO_BITS];
  logic [NUM_BITS-1:0] rm [0:QUO_BITS][0:2];
  quo_vec_t            qq [0:QUO_BITS];

  // Numerator gets half the divisor added for round to nearest
  always_ff @(posedge clk) begin
    if (rst) begin
      cl[0] <= '0;
    end else if (ce) begin
      cl[0] <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dd[0] <= {in_root, 1'b0};
      qq[0] <= '0;
      for (int i = 0; i < 3; i++) begin
        rm[0][i] <= NUM_BITS'({in_m[i], FRAC_SHIFT'(0)}) + NUM_BITS'(in_root);
      end
    end
  end

  for (genvar j = 1; j <= QUO_BITS; j++) begin : g_step
    localparam int B = QUO_BITS - j;
    logic [CMP_BITS-1:0] cmp;
    assign cmp = CMP_BITS'(dd[j-1]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        cl[j] <= '0;
      end else if (ce) begin
        cl[j] <= cl[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        dd[j] <= dd[j-1];
        for (int i = 0; i < 3; i++) begin
          if (CMP_BITS'(rm[j-1][i]) >= cmp) begin
            rm[j][i] <= rm[j-1][i] - NUM_BITS'(cmp);
            qq[j][i] <= qq[j-1][i] | (QUO_BITS'(1) << B);
          end else begin
            rm[j][i] <= rm[j-1][i];
            qq[j][i] <= qq[j-1][i];
          end
        end
      end
    end
  end

  assign out_ctl = cl[QUO_BITS];
  assign out_q   = qq[QUO_BITS];

endmodule
